// ===== design/mclc_pkg.sv =====
package mclc_pkg;

    // Field widths
    localparam int OFFSET_W    = 48;
    localparam int BYTES_W     = 40;
    localparam int ROW_W       = 19;
    localparam int DIM_W       = 15;
    localparam int DEPTH_W     = 12;
    localparam int LEVEL_W     = 4;
    localparam int KIND_W      = 2;
    localparam int BPP_W       = 8;
    localparam int BDIM_W      = 3;

    // Exact internal widths
    localparam int RAW_ROW_W   = DIM_W + BPP_W;          // width * bits per pixel
    localparam int ROW_EXACT_W = RAW_ROW_W - 3;          // ceil of that over 8
    localparam int PROD1_W     = ROW_EXACT_W + DIM_W;    // row bytes * rows
    localparam int PROD2_W     = PROD1_W + DEPTH_W;      // times depth
    localparam int MUL_A_W     = PROD1_W;
    localparam int MUL_B_W     = DIM_W;

    // Default mip level limit
    localparam int MAX_LEVELS_DEF = 15;

    // Descriptor queue depth (power of two)
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;
    localparam logic CFG_IDX_DATA_SIZE = 1'b0;

    // Block dimension codes
    localparam logic [BDIM_W-1:0] BDIM_PIXEL = 3'd1;
    localparam logic [BDIM_W-1:0] BDIM_BLOCK = 3'd4;

    typedef enum logic [KIND_W-1:0] {
        KIND_RAW  = 2'd0,
        KIND_BC8  = 2'd1,
        KIND_BC16 = 2'd2,
        KIND_RSVD = 2'd3
    } block_kind_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ROW,
        BK_MUL_ROWS,
        BK_MUL_DEPTH,
        BK_EMIT,
        BK_STICKY
    } back_state_t;

    typedef struct packed {
        logic                 first_slice;
        logic [DIM_W-1:0]     base_width;
        logic [DIM_W-1:0]     base_height;
        logic [DEPTH_W-1:0]   base_depth;
        logic [LEVEL_W-1:0]   level_count;
        logic [KIND_W-1:0]    block_kind;
        logic [BPP_W-1:0]     bits_per_pixel;
    } in_item_t;

    typedef struct packed {
        logic [OFFSET_W-1:0]  byte_offset;
        logic [BYTES_W-1:0]   level_bytes;
        logic [ROW_W-1:0]     row_bytes;
        logic [DIM_W-1:0]     level_width;
        logic [DIM_W-1:0]     level_height;
        logic [DEPTH_W-1:0]   level_depth;
        logic [BDIM_W-1:0]    block_dim;
        logic                 overrun;
        logic                 last;
    } out_item_t;

    // Classified work descriptor between front and back
    typedef struct packed {
        logic                 first;
        logic [DIM_W-1:0]     width;
        logic [DIM_W-1:0]     height;
        logic [DEPTH_W-1:0]   depth;
        logic [LEVEL_W-1:0]   levels;
        logic                 blocked;
        logic                 wide_block;
        logic [BPP_W-1:0]     bpp;
    } desc_t;

endpackage

// ===== design/mclc_front.sv =====
module mclc_front #(
    parameter int MAX_LEVELS = mclc_pkg::MAX_LEVELS_DEF
) (
    input  mclc_pkg::in_item_t s_data,
    output mclc_pkg::desc_t    desc
);
    import mclc_pkg::*;

    logic [LEVEL_W-1:0] levels_min;
    logic               blocked;
    logic               wide_block;

    // Decode format class; the reserved code acts as 16-byte blocks
    always_comb begin
        unique case (block_kind_t'(s_data.block_kind))
            KIND_RAW: begin
                blocked    = 1'b0;
                wide_block = 1'b0;
            end
            KIND_BC8: begin
                blocked    = 1'b1;
                wide_block = 1'b0;
            end
            KIND_BC16, KIND_RSVD: begin
                blocked    = 1'b1;
                wide_block = 1'b1;
            end
            default: begin
                blocked    = 1'b1;
                wide_block = 1'b1;
            end
        endcase
    end

    // Clamp level count to one at least and the limit at most
    assign levels_min = (s_data.level_count == '0) ? LEVEL_W'(1) : s_data.level_count;

    always_comb begin
        desc.first      = s_data.first_slice;
        desc.width      = s_data.base_width;
        desc.height     = s_data.base_height;
        desc.depth      = s_data.base_depth;
        desc.blocked    = blocked;
        desc.wide_block = wide_block;
        desc.bpp        = s_data.bits_per_pixel;
        if ((LEVEL_W + 1)'(levels_min) > (LEVEL_W + 1)'(MAX_LEVELS)) begin
            desc.levels = LEVEL_W'(MAX_LEVELS);
        end else begin
            desc.levels = levels_min;
        end
    end

endmodule

// ===== design/mclc_queue.sv =====
module mclc_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mclc_pkg::desc_t   push_data,
    output logic              full,
    input  logic              pop,
    output mclc_pkg::desc_t   pop_data,
    output logic              nonempty
);
    import mclc_pkg::*;

    desc_t              slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_next;

    assign full     = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store incoming descriptor
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/mclc_back.sv =====
module mclc_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mclc_pkg::desc_t                   desc,
    input  logic                              desc_valid,
    output logic                              desc_pop,
    input  logic [mclc_pkg::OFFSET_W-1:0]     data_size,
    output mclc_pkg::out_item_t               m_data,
    output logic                              m_valid,
    input  logic                              m_ready
);
    import mclc_pkg::*;

    back_state_t              state_reg, state_next;
    desc_t                    cur_reg, cur_next;
    logic [LEVEL_W-1:0]       lvl_reg, lvl_next;
    logic [OFFSET_W-1:0]      run_reg, run_next;
    logic                     err_reg, err_next;
    logic [ROW_EXACT_W-1:0]   row_reg, row_next;
    logic [DIM_W-1:0]         rows_reg, rows_next;
    logic [PROD2_W-1:0]       mul_reg, mul_next;
    logic                     out_valid_reg, out_valid_next;
    out_item_t                out_reg, out_next;

    logic [MUL_A_W-1:0]           mul_a;
    logic [MUL_B_W-1:0]           mul_b;
    logic [MUL_A_W+MUL_B_W-1:0]   mul_prod;
    logic [RAW_ROW_W-1:0]         raw_prod;
    logic [RAW_ROW_W-1:0]         raw_round;
    logic [DIM_W:0]               bw_sum;
    logic [DIM_W:0]               bh_sum;
    logic [ROW_EXACT_W-1:0]       row_calc;
    logic [DIM_W-1:0]             rows_calc;
    logic [OFFSET_W:0]            end_sum;
    logic                         over;
    logic                         last_level;
    logic                         out_free;
    logic [DIM_W-1:0]             w_half;
    logic [DIM_W-1:0]             h_half;
    logic [DEPTH_W-1:0]           d_half;
    out_item_t                    level_out;

    // Shared size multiplier
    assign mul_prod = mul_a * mul_b;

    // Row bytes and row count of the current level
    assign raw_prod  = RAW_ROW_W'(cur_reg.width) * RAW_ROW_W'(cur_reg.bpp);
    assign raw_round = raw_prod + RAW_ROW_W'(7);
    assign bw_sum    = (DIM_W + 1)'(cur_reg.width) + (DIM_W + 1)'(3);
    assign bh_sum    = (DIM_W + 1)'(cur_reg.height) + (DIM_W + 1)'(3);

    always_comb begin
        if (cur_reg.blocked) begin
            if (cur_reg.wide_block) begin
                row_calc = ROW_EXACT_W'({bw_sum[DIM_W:2], 4'b0});
            end else begin
                row_calc = ROW_EXACT_W'({bw_sum[DIM_W:2], 3'b0});
            end
            rows_calc = DIM_W'(bh_sum[DIM_W:2]);
        end else begin
            row_calc  = raw_round[RAW_ROW_W-1:3];
            rows_calc = cur_reg.height;
        end
    end

    // End of level and overrun test
    assign end_sum    = (OFFSET_W + 1)'(run_reg) + (OFFSET_W + 1)'(mul_reg);
    assign over       = end_sum > {1'b0, data_size};
    assign last_level = (lvl_reg == cur_reg.levels - 1'b1);
    assign out_free   = !out_valid_reg || m_ready;

    // Halve dimensions with a floor of one
    assign w_half = (cur_reg.width  >> 1) == '0 ? DIM_W'(1)   : cur_reg.width  >> 1;
    assign h_half = (cur_reg.height >> 1) == '0 ? DIM_W'(1)   : cur_reg.height >> 1;
    assign d_half = (cur_reg.depth  >> 1) == '0 ? DEPTH_W'(1) : cur_reg.depth  >> 1;

    // Result of the current level, sizes saturated to field range
    always_comb begin
        level_out.byte_offset  = run_reg;
        level_out.level_bytes  = (|mul_reg[PROD2_W-1:BYTES_W]) ? '1 : mul_reg[BYTES_W-1:0];
        level_out.row_bytes    = row_reg[ROW_EXACT_W-1] ? '1 : row_reg[ROW_W-1:0];
        level_out.level_width  = cur_reg.width;
        level_out.level_height = cur_reg.height;
        level_out.level_depth  = cur_reg.depth;
        level_out.block_dim    = cur_reg.blocked ? BDIM_BLOCK : BDIM_PIXEL;
        level_out.overrun      = over;
        level_out.last         = over || last_level;
    end

    // Sequence one item level by level
    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        lvl_next       = lvl_reg;
        run_next       = run_reg;
        err_next       = err_reg;
        row_next       = row_reg;
        rows_next      = rows_reg;
        mul_next       = mul_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        desc_pop       = 1'b0;
        mul_a          = '0;
        mul_b          = '0;

        unique case (state_reg)
            BK_IDLE: begin
                if (desc_valid) begin
                    desc_pop = 1'b1;
                    cur_next = desc;
                    lvl_next = '0;
                    if (desc.first) begin
                        run_next   = '0;
                        err_next   = 1'b0;
                        state_next = BK_ROW;
                    end else if (err_reg) begin
                        state_next = BK_STICKY;
                    end else begin
                        state_next = BK_ROW;
                    end
                end
            end
            BK_ROW: begin
                row_next   = row_calc;
                rows_next  = rows_calc;
                state_next = BK_MUL_ROWS;
            end
            BK_MUL_ROWS: begin
                mul_a      = MUL_A_W'(row_reg);
                mul_b      = rows_reg;
                mul_next   = PROD2_W'(mul_prod);
                state_next = BK_MUL_DEPTH;
            end
            BK_MUL_DEPTH: begin
                mul_a      = mul_reg[MUL_A_W-1:0];
                mul_b      = MUL_B_W'(cur_reg.depth);
                mul_next   = PROD2_W'(mul_prod);
                state_next = BK_EMIT;
            end
            BK_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next       = level_out;
                    if (over) begin
                        err_next   = 1'b1;
                        state_next = BK_IDLE;
                    end else begin
                        run_next = end_sum[OFFSET_W-1:0];
                        if (last_level) begin
                            state_next = BK_IDLE;
                        end else begin
                            cur_next.width  = w_half;
                            cur_next.height = h_half;
                            cur_next.depth  = d_half;
                            lvl_next        = lvl_reg + 1'b1;
                            state_next      = BK_ROW;
                        end
                    end
                end
            end
            BK_STICKY: begin
                if (out_free) begin
                    out_valid_next         = 1'b1;
                    out_next.byte_offset   = run_reg;
                    out_next.level_bytes   = '0;
                    out_next.row_bytes     = '0;
                    out_next.level_width   = '0;
                    out_next.level_height  = '0;
                    out_next.level_depth   = '0;
                    out_next.block_dim     = BDIM_PIXEL;
                    out_next.overrun       = 1'b1;
                    out_next.last          = 1'b1;
                    state_next             = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            run_reg       <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working payload
    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        lvl_reg  <= lvl_next;
        row_reg  <= row_next;
        rows_reg <= rows_next;
        mul_reg  <= mul_next;
        out_reg  <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== design/mip_chain_layout_calculator_top.sv =====
// Mip chain layout calculator.
// Input channel (s_valid/s_ready/s_data): one transfer per array slice with
// base size, level count and format class. Result channel (m_valid/m_ready/
// m_data): one transfer per mip level with offset, size, row bytes and
// dimensions; last marks the final level of a slice. An overrun ends the run
// early and, until a slice with first_slice set, every slice gets one
// overrun result. data_size is written through the APB port at address 0
// (64-bit data, upper 16 bits ignored); the user must write it only while
// the block is idle, which the block itself does not enforce. A slice is
// taken off the queue, then each level runs the row bytes step, two passes
// through the shared size multiplier and the offset add and compare; a
// sticky overrun slice skips these steps and gives its one result.
// A two-entry queue holds classified slices, so input transfers continue
// while the back end works. When the receiver stalls the result register
// holds its transfer and the back end waits at its next result.
// Reset clears the running offset, the error flag, data_size, the queue and
// the result valid flag.
module mip_chain_layout_calculator_top #(
    parameter int MAX_LEVELS = mclc_pkg::MAX_LEVELS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  mclc_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output mclc_pkg::out_item_t               m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mclc_pkg::PADDR_W-1:0]      paddr,
    input  logic [mclc_pkg::PDATA_W-1:0]      pwdata,
    output logic [mclc_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);
    import mclc_pkg::*;

    logic [OFFSET_W-1:0] data_size_reg;
    logic [OFFSET_W-1:0] data_size_next;
    logic                reg_sel;
    desc_t               front_desc;
    desc_t               queue_desc;
    logic                queue_full;
    logic                queue_nonempty;
    logic                queue_pop;
    logic                queue_push;

    // Register decode
    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1] == CFG_IDX_DATA_SIZE);
    assign prdata  = reg_sel ? PDATA_W'(data_size_reg) : '0;

    always_comb begin
        data_size_next = data_size_reg;
        if (psel && penable && pwrite && pready && reg_sel) begin
            data_size_next = pwdata[OFFSET_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_size_reg <= '0;
        end else begin
            data_size_reg <= data_size_next;
        end
    end

    // Accept a slice whenever the queue has room
    assign s_ready    = !queue_full;
    assign queue_push = s_valid && !queue_full;

    mclc_front #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_front (
        .s_data (s_data),
        .desc   (front_desc)
    );

    mclc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (queue_push),
        .push_data (front_desc),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_data  (queue_desc),
        .nonempty  (queue_nonempty)
    );

    mclc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .desc       (queue_desc),
        .desc_valid (queue_nonempty),
        .desc_pop   (queue_pop),
        .data_size  (data_size_reg),
        .m_data     (m_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready)
    );

endmodule

// ===== bench/mip_chain_layout_calculator_top_tb.sv =====
`timescale 1ns / 1ps

module mip_chain_layout_calculator_top_tb;
    import mclc_pkg::*;

    localparam int LEVEL_LIMIT    = MAX_LEVELS_DEF;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int RAND_PHASE_LEN = 70;

    localparam longint unsigned BYTES_MAX = (64'd1 << BYTES_W) - 64'd1;
    localparam longint unsigned ROW_MAX   = (64'd1 << ROW_W) - 64'd1;
    localparam logic [OFFSET_W-1:0] SIZE_MAX = '1;
    localparam logic [PADDR_W-1:0] ADDR_DATA_SIZE = PADDR_W'(CFG_IDX_DATA_SIZE) << 3;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_item_t            s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_item_t           m_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Predicted layout state, mirrored from the block
    out_item_t           mip_expect_q[$];
    out_item_t           expd;
    logic [OFFSET_W-1:0] run_offset    = '0;
    logic                chain_broken  = 1'b0;
    logic [OFFSET_W-1:0] data_size_cfg = '0;

    int fail_count  = 0;
    int cycle_count = 0;
    int burst_left  = 0;

    // Receiver pattern controls
    bit rx_stall_en   = 1'b0;
    bit rx_hold_req   = 1'b0;
    int rx_hold_left  = 0;
    int rx_phase_left = 0;

    mip_chain_layout_calculator_top #(
        .MAX_LEVELS (LEVEL_LIMIT)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL mip_chain_layout_calculator_top");
            $finish;
        end
    end

    // Compute the level records that one slice produces and queue them
    function automatic void predict_layout(input in_item_t it);
        longint unsigned w, h, d, n, bpp, row, rows, bytes, end_pos;
        logic [BDIM_W-1:0] bdim;
        block_kind_t kind;
        out_item_t lvl;
        w    = it.base_width;
        h    = it.base_height;
        d    = it.base_depth;
        n    = it.level_count;
        bpp  = it.bits_per_pixel;
        kind = block_kind_t'(it.block_kind);
        if (it.first_slice) begin
            run_offset   = '0;
            chain_broken = 1'b0;
        end
        // Sticky error: one empty overrun record per slice
        if (chain_broken) begin
            lvl             = '0;
            lvl.byte_offset = run_offset;
            lvl.block_dim   = BDIM_PIXEL;
            lvl.overrun     = 1'b1;
            lvl.last        = 1'b1;
            mip_expect_q.push_back(lvl);
            return;
        end
        if (n == 0) n = 1;
        if (n > LEVEL_LIMIT) n = LEVEL_LIMIT;
        for (int i = 0; i < n; i++) begin
            if (kind != KIND_RAW) begin
                row  = (w == 0) ? 0 : ((w + 3) / 4) * ((kind == KIND_BC8) ? 8 : 16);
                rows = (h == 0) ? 0 : (h + 3) / 4;
                bdim = BDIM_BLOCK;
            end else begin
                row  = (w * bpp + 7) / 8;
                rows = h;
                bdim = BDIM_PIXEL;
            end
            bytes   = row * rows * d;
            end_pos = run_offset + bytes;
            lvl.byte_offset  = run_offset;
            lvl.level_bytes  = BYTES_W'((bytes > BYTES_MAX) ? BYTES_MAX : bytes);
            lvl.row_bytes    = ROW_W'((row > ROW_MAX) ? ROW_MAX : row);
            lvl.level_width  = DIM_W'(w);
            lvl.level_height = DIM_W'(h);
            lvl.level_depth  = DEPTH_W'(d);
            lvl.block_dim    = bdim;
            // Overrun ends the chain and latches the error
            if (end_pos > data_size_cfg) begin
                lvl.overrun  = 1'b1;
                lvl.last     = 1'b1;
                mip_expect_q.push_back(lvl);
                chain_broken = 1'b1;
                return;
            end
            lvl.overrun = 1'b0;
            lvl.last    = (i + 1 == n);
            mip_expect_q.push_back(lvl);
            run_offset = OFFSET_W'(end_pos);
            w = (w >> 1 == 0) ? 1 : w >> 1;
            h = (h >> 1 == 0) ? 1 : h >> 1;
            d = (d >> 1 == 0) ? 1 : d >> 1;
        end
    endfunction

    task automatic check_field(input string field, input logic [63:0] expv,
                               input logic [63:0] gotv);
        if (expv !== gotv) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expv, gotv);
            fail_count++;
        end
    endtask

    // Check each result transfer, then predict each accepted slice
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (mip_expect_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, m_data);
                fail_count++;
            end else begin
                expd = mip_expect_q.pop_front();
                check_field("byte_offset", expd.byte_offset, m_data.byte_offset);
                check_field("level_bytes", expd.level_bytes, m_data.level_bytes);
                check_field("row_bytes", expd.row_bytes, m_data.row_bytes);
                check_field("level_width", expd.level_width, m_data.level_width);
                check_field("level_height", expd.level_height, m_data.level_height);
                check_field("level_depth", expd.level_depth, m_data.level_depth);
                check_field("block_dim", expd.block_dim, m_data.block_dim);
                check_field("overrun", expd.overrun, m_data.overrun);
                check_field("last", expd.last, m_data.last);
            end
        end
        if (aresetn && s_valid && s_ready)
            predict_layout(s_data);
    end

    // Receiver: long hold on request, else always ready or, with stalls enabled, alternate ready runs and stalls
    always @(posedge aclk) begin
        if (rx_hold_req) begin
            rx_hold_req  = 1'b0;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else if (!rx_stall_en) begin
            m_ready <= 1'b1;
        end else if (rx_phase_left > 0) begin
            rx_phase_left--;
        end else if (m_ready) begin
            m_ready <= 1'b0;
            rx_phase_left = $urandom_range(0, 7);
        end else begin
            m_ready <= 1'b1;
            rx_phase_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                        : $urandom_range(0, 9);
        end
    end

    function automatic in_item_t make_slice(input bit first, input int w, input int h,
                                            input int d, input int n, input block_kind_t kind,
                                            input int bpp);
        in_item_t it;
        it.first_slice    = first;
        it.base_width     = DIM_W'(w);
        it.base_height    = DIM_W'(h);
        it.base_depth     = DEPTH_W'(d);
        it.level_count    = LEVEL_W'(n);
        it.block_kind     = kind;
        it.bits_per_pixel = BPP_W'(bpp);
        return it;
    endfunction

    function automatic int rand_dim();
        case ($urandom_range(0, 19))
            0:       return 0;
            1, 2:    return $urandom_range(0, 32767);
            3:       return ($urandom_range(0, 1) == 0) ? 16384 : 32767;
            4, 5, 6, 7, 8: return $urandom_range(1, 2048);
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    function automatic in_item_t rand_slice();
        int d, bpp;
        block_kind_t kind;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: kind = KIND_RAW;
            4, 5:       kind = KIND_BC8;
            6, 7, 8:    kind = KIND_BC16;
            default:    kind = KIND_RSVD;
        endcase
        case ($urandom_range(0, 9))
            0:       d = $urandom_range(0, 4095);
            1, 2:    d = $urandom_range(1, 8);
            default: d = 1;
        endcase
        bpp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 16) * 8;
        return make_slice($urandom_range(0, 4) == 0, rand_dim(), rand_dim(), d,
                          $urandom_range(0, 15), kind, bpp);
    endfunction

    // Offer one slice and hold it until the transfer
    task automatic send_slice(input in_item_t it);
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic idle_sender(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // End a burst with a random gap and pick the next burst length
    task automatic pace_sender();
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            idle_sender($urandom_range(1, 12));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // Stop offering and wait until every expected level has arrived
    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (mip_expect_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_data_size(input logic [OFFSET_W-1:0] size);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_DATA_SIZE;
        pwdata  <= {16'($urandom), size};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        data_size_cfg = size;
    endtask

    // Zero data size after reset, then an explicit zero write
    task automatic test_reset_state();
        send_slice(make_slice(1, 4, 4, 1, 3, KIND_RAW, 0));
        send_slice(make_slice(0, 2, 2, 1, 1, KIND_RAW, 8));
        send_slice(make_slice(0, 9, 9, 1, 2, KIND_BC8, 0));
        send_slice(make_slice(1, 0, 5, 1, 2, KIND_RAW, 32));
        wait_drain();
        write_data_size('0);
        send_slice(make_slice(1, 8, 8, 0, 3, KIND_BC16, 0));
        wait_drain();
    endtask

    // Every format class, level count extremes and size extremes
    task automatic test_formats();
        write_data_size(SIZE_MAX);
        rx_stall_en = 1'b1;
        send_slice(make_slice(1, 16, 8, 1, 5, KIND_RAW, 32));
        send_slice(make_slice(0, 7, 3, 1, 4, KIND_RAW, 24));
        send_slice(make_slice(0, 9, 1, 1, 2, KIND_RAW, 1));
        send_slice(make_slice(0, 1, 1, 1, 15, KIND_RAW, 128));
        send_slice(make_slice(0, 13, 7, 1, 5, KIND_BC8, 0));
        send_slice(make_slice(1, 16384, 16384, 1, 15, KIND_BC16, 255));
        send_slice(make_slice(0, 64, 32, 1, 7, KIND_RSVD, 8));
        send_slice(make_slice(0, 20, 20, 1, 0, KIND_RAW, 16));
        send_slice(make_slice(0, 100, 100, 1, 3, KIND_RAW, 0));
        send_slice(make_slice(0, 37, 0, 1, 4, KIND_BC8, 8));
        send_slice(make_slice(0, 0, 12, 3, 4, KIND_RAW, 64));
        send_slice(make_slice(0, 16, 16, 2048, 12, KIND_RAW, 8));
        idle_sender(3);
        send_slice(make_slice(1, 32767, 32767, 4095, 15, KIND_RAW, 255));
        send_slice(make_slice(1, 32767, 32767, 4095, 15, KIND_BC16, 255));
        wait_drain();
    endtask

    // Overrun mid-stream, sticky error, recovery on a new texture
    task automatic test_overrun_chain();
        write_data_size(OFFSET_W'(200));
        send_slice(make_slice(1, 8, 8, 1, 4, KIND_RAW, 8));
        send_slice(make_slice(0, 8, 8, 1, 4, KIND_RAW, 8));
        send_slice(make_slice(0, 8, 8, 1, 4, KIND_RAW, 8));
        send_slice(make_slice(0, 2, 2, 1, 1, KIND_RAW, 8));
        send_slice(make_slice(1, 8, 8, 1, 4, KIND_RAW, 8));
        wait_drain();
    endtask

    // Hold the receiver off so the block fills and stalls its input
    task automatic test_backpressure();
        write_data_size(SIZE_MAX);
        rx_hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_slice(make_slice(i == 0, $urandom_range(1, 64), $urandom_range(1, 64), 1,
                                  15, block_kind_t'($urandom_range(0, 3)), 32));
        wait_drain();
    endtask

    // Random slices under several data sizes with bursty traffic
    task automatic test_random();
        logic [OFFSET_W-1:0] sizes[4];
        sizes[0] = SIZE_MAX;
        sizes[1] = OFFSET_W'($urandom_range(4096, 65535));
        sizes[2] = OFFSET_W'($urandom);
        sizes[3] = {16'($urandom), 32'($urandom)};
        for (int p = 0; p < 4; p++) begin
            write_data_size(sizes[p]);
            rx_stall_en = (p != 2);
            burst_left  = 0;
            for (int i = 0; i < RAND_PHASE_LEN; i++) begin
                send_slice(rand_slice());
                pace_sender();
            end
            wait_drain();
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_formats();
        test_overrun_chain();
        test_backpressure();
        test_random();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("PASS mip_chain_layout_calculator_top");
        else
            $display("FAIL mip_chain_layout_calculator_top");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mclc_pkg.sv
design/mclc_front.sv
design/mclc_queue.sv
design/mclc_back.sv
design/mip_chain_layout_calculator_top.sv
bench/mip_chain_layout_calculator_top_tb.sv
